// ===== src/lcdseq_pkg.sv =====
// Shared types, codes and constant tables for the character LCD bus sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lcdseq_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [13:0] HOLD_POWER_US  = 14'd15000;
    localparam logic [13:0] HOLD_STROBE_US = 14'd40;
    localparam logic [13:0] HOLD_SETTLE_US = 14'd100;
    localparam logic [13:0] HOLD_GAP_US    = 14'd100;
    localparam logic [13:0] HOLD_CLEAR_US  = 14'd1500;

    localparam logic [2:0] SHIFT_MAX   = 3'd4;
    localparam logic [2:0] SHIFT_RESET = 3'd4;
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;
    localparam logic [7:0] FULL_MASK   = 8'hFF;

    localparam logic [2:0] INIT4_LEN = 3'd6;
    localparam logic [2:0] INIT8_LEN = 3'd4;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_CMD    = 2'd1,
        OP_CHAR   = 2'd2,
        OP_CURSOR = 2'd3
    } op_t;

    typedef enum logic {
        CFG_BUS_MODE     = 1'b0,
        CFG_NIBBLE_SHIFT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        TR_NONE,
        TR_GAP,
        TR_CLEAR
    } trail_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POWER,
        BK_BYTE
    } bk_state_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
        logic [5:0] column;
        logic [1:0] row;
    } in_item_t;

    typedef struct packed {
        logic        reg_select;
        logic        read_write;
        logic        enable;
        logic [7:0]  data_bits;
        logic [7:0]  data_mask;
        logic [13:0] hold_us;
        logic        last;
    } out_item_t;

    // one decoded request as handed from front to back
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] byte_value;
        trail_t     trail;
        logic       bus_8bit;
        logic [2:0] shift;
        logic [7:0] mask;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] b;
        unique case (row)
            2'd0:    b = 8'h80;
            2'd1:    b = 8'hC0;
            2'd2:    b = 8'h90;
            default: b = 8'hD0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] init_byte(input logic bus_8bit, input logic [2:0] idx);
        logic [7:0] b;
        if (bus_8bit) begin
            unique case (idx)
                3'd0:    b = 8'h38;
                3'd1:    b = 8'h0E;
                3'd2:    b = 8'h06;
                default: b = 8'h01;
            endcase
        end else begin
            unique case (idx)
                3'd0:    b = 8'h33;
                3'd1:    b = 8'h32;
                3'd2:    b = 8'h28;
                3'd3:    b = 8'h0E;
                3'd4:    b = 8'h06;
                default: b = 8'h01;
            endcase
        end
        return b;
    endfunction

    function automatic logic [13:0] trail_us(input trail_t tr);
        logic [13:0] t;
        unique case (tr)
            TR_GAP:   t = HOLD_GAP_US;
            TR_CLEAR: t = HOLD_CLEAR_US;
            default:  t = 14'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== src/lcdseq_front.sv =====
// Front end: configuration registers, request intake and decode into jobs.
// Depends on lcdseq_pkg.
`default_nettype none

module lcdseq_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire lcdseq_pkg::in_item_t in_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [2:0]           cfg_data,
    input  wire lcdseq_pkg::q_status_t q_status,
    output logic                      push,
    output lcdseq_pkg::job_t          push_job
);
    import lcdseq_pkg::*;

    logic       bus_mode_reg, bus_mode_next;
    logic [2:0] shift_reg, shift_next;
    logic [2:0] eff_shift;
    op_t        op;

    assign cfg_ready = 1'b1;

    always_comb begin
        bus_mode_next = bus_mode_reg;
        shift_next    = shift_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BUS_MODE:     bus_mode_next = cfg_data[0];
                CFG_NIBBLE_SHIFT: shift_next    = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bus_mode_reg <= 1'b0;
            shift_reg    <= SHIFT_RESET;
        end else begin
            bus_mode_reg <= bus_mode_next;
            shift_reg    <= shift_next;
        end
    end

    // shifts above four saturate so the nibble stays on the port
    assign eff_shift = (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;
    assign op        = op_t'(in_data.opcode);

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    always_comb begin
        push_job          = '0;
        push_job.bus_8bit = bus_mode_reg;
        push_job.shift    = eff_shift;
        push_job.mask     = bus_mode_reg ? FULL_MASK : (NIBBLE_MASK << eff_shift);
        unique case (op)
            OP_INIT: begin
                push_job.is_init = 1'b1;
                push_job.trail   = TR_GAP;
            end
            OP_CMD: begin
                push_job.byte_value = in_data.byte_value;
                push_job.trail      = TR_NONE;
            end
            OP_CHAR: begin
                push_job.rs         = 1'b1;
                push_job.byte_value = in_data.byte_value;
                push_job.trail      = TR_NONE;
            end
            default: begin
                push_job.byte_value = row_base(in_data.row) + {2'b00, in_data.column};
                push_job.trail      = TR_GAP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/lcdseq_queue.sv =====
// Short job queue between the front end and the phase generator.
// Depends on lcdseq_pkg.
`default_nettype none

module lcdseq_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lcdseq_pkg::job_t  push_job,
    input  wire logic              pop,
    output lcdseq_pkg::job_t       head,
    output lcdseq_pkg::q_status_t  status
);
    import lcdseq_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== src/lcdseq_back.sv =====
// Back end: steps through the bus phases of each job, one phase per cycle while
// the output is taken, into an output register. Depends on lcdseq_pkg.
`default_nettype none

module lcdseq_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lcdseq_pkg::job_t      head,
    input  wire lcdseq_pkg::q_status_t q_status,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output lcdseq_pkg::out_item_t      out_data
);
    import lcdseq_pkg::*;

    bk_state_t  state_reg, state_next;
    job_t       job_reg, job_next;
    logic [2:0] byte_idx_reg, byte_idx_next;
    logic [1:0] ph_idx_reg, ph_idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;

    logic       advance;
    logic       emit;
    logic       byte_end;
    logic       last_byte;
    logic       op_done;
    logic [7:0] cur_byte;
    logic [7:0] hi_bits, lo_bits;
    logic [13:0] trail;
    out_item_t  phase;

    assign advance = !out_valid_reg || out_ready;
    assign emit    = (state_reg != BK_IDLE) && advance;

    // ---------------- phase generation ----------------
    always_comb begin
        cur_byte  = job_reg.is_init ? init_byte(job_reg.bus_8bit, byte_idx_reg)
                                    : job_reg.byte_value;
        last_byte = !job_reg.is_init ||
                    (byte_idx_reg == (job_reg.bus_8bit ? INIT8_LEN : INIT4_LEN) - 3'd1);
        trail     = job_reg.is_init ? trail_us(last_byte ? TR_CLEAR : TR_GAP)
                                    : trail_us(job_reg.trail);
        hi_bits   = {4'h0, cur_byte[7:4]} << job_reg.shift;
        lo_bits   = {4'h0, cur_byte[3:0]} << job_reg.shift;
        byte_end  = job_reg.bus_8bit ? (ph_idx_reg == 2'd1) : (ph_idx_reg == 2'd3);
        op_done   = (state_reg == BK_BYTE) && byte_end && last_byte;

        phase            = '0;
        phase.reg_select = job_reg.rs;
        phase.data_mask  = job_reg.mask;
        phase.last       = op_done;
        if (state_reg == BK_POWER) begin
            phase.reg_select = 1'b0;
            phase.hold_us    = HOLD_POWER_US;
        end else if (job_reg.bus_8bit) begin
            phase.enable    = (ph_idx_reg == 2'd0);
            phase.data_bits = cur_byte;
            phase.hold_us   = phase.enable ? HOLD_STROBE_US : HOLD_SETTLE_US + trail;
        end else begin
            phase.enable    = !ph_idx_reg[0];
            phase.data_bits = ph_idx_reg[1] ? lo_bits : hi_bits;
            priority case (1'b1)
                !ph_idx_reg[0]:     phase.hold_us = HOLD_STROBE_US;
                ph_idx_reg == 2'd1: phase.hold_us = HOLD_SETTLE_US;
                default:            phase.hold_us = trail;
            endcase
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        state_next    = state_reg;
        job_next      = job_reg;
        byte_idx_next = byte_idx_reg;
        ph_idx_next   = ph_idx_reg;
        pop           = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    pop           = 1'b1;
                    job_next      = head;
                    byte_idx_next = '0;
                    ph_idx_next   = '0;
                    state_next    = head.is_init ? BK_POWER : BK_BYTE;
                end
            end
            BK_POWER: begin
                if (advance) begin
                    state_next = BK_BYTE;
                end
            end
            default: begin
                if (advance) begin
                    if (op_done) begin
                        // chain straight into the next queued job
                        byte_idx_next = '0;
                        ph_idx_next   = '0;
                        if (!q_status.empty) begin
                            pop        = 1'b1;
                            job_next   = head;
                            state_next = head.is_init ? BK_POWER : BK_BYTE;
                        end else begin
                            state_next = BK_IDLE;
                        end
                    end else if (byte_end) begin
                        byte_idx_next = byte_idx_reg + 3'd1;
                        ph_idx_next   = '0;
                    end else begin
                        ph_idx_next = ph_idx_reg + 2'd1;
                    end
                end
            end
        endcase
    end

    // ---------------- output register ----------------
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance) begin
            out_valid_next = emit;
            out_data_next  = phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            byte_idx_reg  <= '0;
            ph_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            byte_idx_reg  <= byte_idx_next;
            ph_idx_reg    <= ph_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        job_reg      <= job_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== src/char_lcd_bus_sequencer_core.sv =====
// Top level of the character LCD bus sequencer: front end, job queue, phase generator.
// Depends on lcdseq_pkg, lcdseq_front, lcdseq_queue, lcdseq_back.
//
// Each request (initialize, command byte, character byte, cursor position) is
// turned into a run of bus phases, one phase per output item, with RS/RW/EN
// levels, data and mask, and a hold time in microseconds; the final phase of a
// request has last set. The phase generator issues one phase per clock while the
// output is taken. A byte is a strobe and a settle phase in 8-bit mode and such a
// pair per nibble in 4-bit mode; initialize adds a power-on wait phase, and a
// request that reaches an idle generator is first loaded into the job register.
// Requests are accepted while earlier ones are still being played out, as long
// as the two-entry job queue has room; so the sustained rate is set by the phase
// count of each request. Configuration (bus_mode at index 0, nibble_shift at
// index 1) is always ready and must only be written while nothing is in flight.
`default_nettype none

module char_lcd_bus_sequencer_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire lcdseq_pkg::in_item_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output lcdseq_pkg::out_item_t      out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_index,
    input  wire logic [2:0]            cfg_data
);
    import lcdseq_pkg::*;

    job_t      push_job;
    job_t      head;
    q_status_t q_status;
    logic      push;
    logic      pop;

    lcdseq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    lcdseq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    lcdseq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== src/lcdseq_checker.sv =====
// Port-level checks for the character LCD bus sequencer, bound to the top level.
// Depends on lcdseq_pkg and char_lcd_bus_sequencer_core.
`default_nettype none

module lcdseq_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire lcdseq_pkg::out_item_t out_data
);
    import lcdseq_pkg::*;

    // a stalled phase stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output phase changed while stalled");

    a_rw_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !out_data.read_write)
        else $error("RW driven high");

    // strobe phases are fixed length and never close a request
    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.enable |-> out_data.hold_us == HOLD_STROBE_US && !out_data.last)
        else $error("bad strobe phase");

    // the power-on wait is followed by an EN-high strobe of the first command
    a_power: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.hold_us == HOLD_POWER_US |->
            !out_data.enable && out_data.data_bits == 8'h00 && !out_data.last
            ##1 (!out_valid || out_data.enable))
        else $error("bad power-on phase");

endmodule

bind char_lcd_bus_sequencer_core lcdseq_checker u_lcdseq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_bus_sequencer_core: directed and random requests,
// each checked phase by phase against a behavioral model. Depends on lcdseq_pkg and the core.

module tb;
    import lcdseq_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PCT     = 13;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 40;
    localparam int SEG_ITEMS    = 22;
    localparam int SEGMENTS     = 5;
    localparam int MAX_REPORTS  = 10;

    localparam logic [0:5][7:0] BOOT4    = {8'h33, 8'h32, 8'h28, 8'h0E, 8'h06, 8'h01};
    localparam logic [0:3][7:0] BOOT8    = {8'h38, 8'h0E, 8'h06, 8'h01};
    localparam logic [0:3][7:0] ROW_BASE = {8'h80, 8'hC0, 8'h90, 8'hD0};

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    cfg_idx_t  cfg_index = CFG_BUS_MODE;
    logic [2:0] cfg_data = 3'd0;

    // model copy of the two registers
    logic       mdl_bus8  = 1'b0;
    logic [2:0] mdl_shift = SHIFT_RESET;

    out_item_t expected_phases [$];
    logic      calm = 1'b0;
    int        cycles = 0;
    int        err_count = 0;
    int        phases_checked = 0;
    int        cfg_settings = 1;
    int        op_count [4] = '{0, 0, 0, 0};

    char_lcd_bus_sequencer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    // ---------------- phase model ----------------

    task automatic push_phase(input logic rs, input logic en, input logic [7:0] d,
                              input logic [7:0] m, input logic [13:0] h, input logic fin);
        out_item_t p;
        p.reg_select = rs;
        p.read_write = 1'b0;
        p.enable     = en;
        p.data_bits  = d;
        p.data_mask  = m;
        p.hold_us    = h;
        p.last       = fin;
        expected_phases.push_back(p);
    endtask

    task automatic plan_byte(input logic rs, input logic [7:0] b, input logic [13:0] trail,
                             input logic [2:0] sh, input logic fin);
        logic [7:0] mask;
        logic [7:0] hi;
        logic [7:0] lo;
        if (mdl_bus8)
        begin
            push_phase(rs, 1'b1, b, FULL_MASK, HOLD_STROBE_US, 1'b0);
            push_phase(rs, 1'b0, b, FULL_MASK, HOLD_SETTLE_US + trail, fin);
        end
        else
        begin
            mask = NIBBLE_MASK << sh;
            hi   = ({4'h0, b[7:4]} << sh) & mask;
            lo   = ({4'h0, b[3:0]} << sh) & mask;
            push_phase(rs, 1'b1, hi, mask, HOLD_STROBE_US, 1'b0);
            push_phase(rs, 1'b0, hi, mask, HOLD_SETTLE_US, 1'b0);
            push_phase(rs, 1'b1, lo, mask, HOLD_STROBE_US, 1'b0);
            push_phase(rs, 1'b0, lo, mask, trail, fin);
        end
    endtask

    task automatic plan_phases(input in_item_t it);
        logic [2:0]  sh;
        logic [7:0]  mask;
        logic [7:0]  addr;
        logic [13:0] trail;
        // shift values above four saturate
        sh   = (mdl_shift > SHIFT_MAX) ? SHIFT_MAX : mdl_shift;
        mask = mdl_bus8 ? FULL_MASK : (NIBBLE_MASK << sh);
        case (it.opcode)
            OP_INIT:
            begin
                push_phase(1'b0, 1'b0, 8'h00, mask, HOLD_POWER_US, 1'b0);
                if (mdl_bus8)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        trail = (i == 3) ? HOLD_CLEAR_US : HOLD_GAP_US;
                        plan_byte(1'b0, BOOT8[i], trail, sh, i == 3);
                    end
                end
                else
                begin
                    for (int i = 0; i < 6; i++)
                    begin
                        trail = (i == 5) ? HOLD_CLEAR_US : HOLD_GAP_US;
                        plan_byte(1'b0, BOOT4[i], trail, sh, i == 5);
                    end
                end
            end
            OP_CMD:  plan_byte(1'b0, it.byte_value, 14'd0, sh, 1'b1);
            OP_CHAR: plan_byte(1'b1, it.byte_value, 14'd0, sh, 1'b1);
            default:
            begin
                addr = ROW_BASE[it.row] + {2'b00, it.column};
                plan_byte(1'b0, addr, HOLD_GAP_US, sh, 1'b1);
            end
        endcase
    endtask

    // ---------------- result side ----------------

    function automatic string phase_str(input out_item_t p);
        return $sformatf("rs=%0b rw=%0b en=%0b data=%02h mask=%02h hold=%0d last=%0b",
                         p.reg_select, p.read_write, p.enable, p.data_bits, p.data_mask,
                         p.hold_us, p.last);
    endfunction

    task automatic check_phase(input out_item_t got);
        out_item_t want;
        logic      bad;
        if (expected_phases.size() == 0)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: unexpected phase, none pending: %s", $realtime, phase_str(got));
        end
        else
        begin
            want = expected_phases.pop_front();
            phases_checked++;
            bad = (got.reg_select !== want.reg_select) || (got.read_write !== want.read_write)
                  || (got.enable !== want.enable) || (got.data_bits !== want.data_bits)
                  || (got.data_mask !== want.data_mask) || (got.hold_us !== want.hold_us)
                  || (got.last !== want.last);
            if (bad)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: phase mismatch\n  exp %s\n  got %s", $realtime,
                             phase_str(want), phase_str(got));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_phase(out_data);
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // ---------------- request side ----------------

    task automatic send_req(input op_t op, input logic [7:0] b, input logic [5:0] col,
                            input logic [1:0] row);
        in_item_t it;
        it.opcode     = op;
        it.byte_value = b;
        it.column     = col;
        it.row        = row;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        plan_phases(it);
        op_count[op]++;
    endtask

    task automatic send_random();
        op_t op;
        op = ($urandom_range(99) < 8) ? OP_INIT : op_t'($urandom_range(1, 3));
        send_req(op, 8'($urandom_range(255)), 6'($urandom_range(63)), 2'($urandom_range(3)));
    endtask

    // hold off new requests until every pending phase has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_phases.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_idx_t idx, input logic [2:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_BUS_MODE)
            mdl_bus8 = val[0];
        else
            mdl_shift = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_defaults();
        send_req(OP_INIT, 8'h00, 6'd0, 2'd0);
        send_req(OP_CMD, 8'h00, 6'd63, 2'd3);
        send_req(OP_CHAR, 8'hFF, 6'd0, 2'd0);
        send_req(OP_CURSOR, 8'hFF, 6'd0, 2'd0);
        // D0 + 63 wraps past 0xFF
        send_req(OP_CURSOR, 8'h00, 6'd63, 2'd3);
        send_req(OP_CHAR, 8'hA5, 6'd21, 2'd1);
        wait_idle();
    endtask

    task automatic test_8bit_bus();
        // upper data bits must be ignored for the mode register
        write_cfg(CFG_BUS_MODE, 3'b111);
        cfg_settings++;
        send_req(OP_INIT, 8'hFF, 6'd63, 2'd3);
        send_req(OP_CMD, 8'hFF, 6'd0, 2'd0);
        send_req(OP_CHAR, 8'h00, 6'd63, 2'd3);
        send_req(OP_CURSOR, 8'h00, 6'd63, 2'd1);
        send_req(OP_CURSOR, 8'hFF, 6'd0, 2'd2);
        send_req(OP_CHAR, 8'h5A, 6'd42, 2'd2);
        wait_idle();
    endtask

    task automatic test_nibble_shift();
        logic [2:0] shifts [4];
        shifts = '{3'd0, 3'd3, 3'd5, 3'd7};
        write_cfg(CFG_BUS_MODE, 3'b110);
        for (int i = 0; i < 4; i++)
        begin
            write_cfg(CFG_NIBBLE_SHIFT, shifts[i]);
            cfg_settings++;
            if (i == 0)
                send_req(OP_INIT, 8'h3C, 6'd5, 2'd1);
            send_req(OP_CHAR, 8'h96, 6'd1, 2'd2);
            send_req(OP_CMD, 8'h69, 6'd62, 2'd1);
            wait_idle();
        end
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:
                begin
                    write_cfg(CFG_BUS_MODE, {2'($urandom_range(3)), 1'b1});
                    write_cfg(CFG_NIBBLE_SHIFT, 3'($urandom_range(7)));
                end
                1:
                begin
                    write_cfg(CFG_BUS_MODE, {2'($urandom_range(3)), 1'b0});
                    write_cfg(CFG_NIBBLE_SHIFT, 3'd0);
                end
                2:
                begin
                    write_cfg(CFG_BUS_MODE, 3'b000);
                    write_cfg(CFG_NIBBLE_SHIFT, 3'd4);
                end
                3:
                begin
                    write_cfg(CFG_BUS_MODE, 3'b010);
                    write_cfg(CFG_NIBBLE_SHIFT, 3'($urandom_range(5, 7)));
                end
                default:
                begin
                    write_cfg(CFG_BUS_MODE, 3'($urandom_range(7)));
                    write_cfg(CFG_NIBBLE_SHIFT, 3'($urandom_range(7)));
                end
            endcase
            cfg_settings++;
            // one segment runs back to back with no gaps or stalls
            calm = (seg == 2);
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                if (seg == 3 && n == SEG_ITEMS / 2)
                    wait_idle();
                send_random();
            end
            wait_idle();
            calm = 1'b0;
        end
    endtask

    // ---------------- sequencing ----------------

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d phases pending", cycles,
                 expected_phases.size());
        $display("[char_lcd_bus_sequencer_core] ERROR");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_8bit_bus();
        test_nibble_shift();
        test_random_traffic();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("requests: %0d init, %0d command, %0d character, %0d cursor over %0d settings",
                 op_count[OP_INIT], op_count[OP_CMD], op_count[OP_CHAR], op_count[OP_CURSOR],
                 cfg_settings);
        $display("bus phases checked: %0d, errors: %0d", phases_checked, err_count);
        if (err_count == 0)
            $display("[char_lcd_bus_sequencer_core] OK");
        else
            $display("[char_lcd_bus_sequencer_core] ERROR");
        $finish;
    end

endmodule
